/* hdl/xmd_pkg.sv */
// xmd_pkg: shared types and constants for the x86-64 prefix / ModRM decoder.
// Used by the top level and the assertion checker; depends on nothing.
package xmd_pkg;

  localparam int WIN_MAX   = 15;
  localparam int PTR_W     = 5;
  localparam int RIP_OFS_W = 6;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  localparam logic [7:0] PFX_OPSIZE   = 8'h66;
  localparam logic [7:0] PFX_ADDRSIZE = 8'h67;
  localparam logic [7:0] PFX_FS       = 8'h64;
  localparam logic [7:0] PFX_GS       = 8'h65;
  localparam logic [7:0] PFX_ES       = 8'h26;
  localparam logic [7:0] PFX_CS       = 8'h2E;
  localparam logic [7:0] PFX_SS       = 8'h36;
  localparam logic [7:0] PFX_DS       = 8'h3E;
  localparam logic [7:0] PFX_LOCK     = 8'hF0;
  localparam logic [7:0] PFX_REPNE    = 8'hF2;
  localparam logic [7:0] PFX_REP      = 8'hF3;
  localparam logic [3:0] REX_HI       = 4'h4;

  localparam logic [1:0] SEG_NONE = 2'd0;
  localparam logic [1:0] SEG_FS   = 2'd1;
  localparam logic [1:0] SEG_GS   = 2'd2;
  localparam logic [1:0] REP_NONE = 2'd0;
  localparam logic [1:0] REP_F2   = 2'd1;
  localparam logic [1:0] REP_F3   = 2'd2;

  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;
  localparam logic [2:0] RM_SIB     = 3'd4;
  localparam logic [2:0] RM_RIP     = 3'd5;
  localparam logic [2:0] SIB_NOIDX  = 3'd4;
  localparam logic [2:0] SIB_NOBASE = 3'd5;

  localparam logic [2:0] DISP_NONE = 3'd0;
  localparam logic [2:0] DISP_BYTE = 3'd1;
  localparam logic [2:0] DISP_WORD = 3'd4;

  localparam logic [63:0] ADDR32_MASK = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MODRM,
    ST_SIB,
    ST_RIPA,
    ST_RIPB,
    ST_RDB,
    ST_ADDB,
    ST_RDI,
    ST_ADDI,
    ST_DISP,
    ST_ADDD,
    ST_DONE
  } state_t;

endpackage

/* hdl/xmd_regfile.sv */
// xmd_regfile: general register file, one write port, one registered read port.
// Per-entry valid bits give the all-zero reset; no package dependency.
module xmd_regfile #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

/* hdl/x86_64_prefix_modrm_decoder.sv */
// x86_64_prefix_modrm_decoder: prefix scan and ModRM/SIB effective address decode.
// Depends on xmd_pkg and xmd_regfile.
//
//  channel   handshake        payload
//  input     start / busy     kind, reg_number, reg_value, instr_addr, bytes_lo,
//                             bytes_hi, opcode_len, trailing_imm
//  result    done (1 cycle)   prefix_len ... modrm_len
//
// A register write is accepted while idle and busy stays low. A decode walks the window
// one byte a cycle through a single byte mux and sums the address on one 64-bit
// adder: it scans the legacy prefixes, reads ModRM, then SIB or the RIP-relative terms,
// reads and adds the base and index registers, gathers and adds the displacement
// bytes and raises the strobe. Reset is synchronous and clears the register
// file valid bits and the sequencer. Results cannot be stalled.
module x86_64_prefix_modrm_decoder #(
  parameter int WINDOW_BYTES = 15,
  parameter int REG_COUNT    = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind,
  input  logic [$clog2(REG_COUNT)-1:0] reg_number,
  input  logic [63:0]                  reg_value,
  input  logic [63:0]                  instr_addr,
  input  logic [63:0]                  bytes_lo,
  input  logic [55:0]                  bytes_hi,
  input  logic [1:0]                   opcode_len,
  input  logic [3:0]                   trailing_imm,
  output logic                         done,
  output logic [3:0]                   prefix_len,
  output logic [6:0]                   rex_byte,
  output logic                         opsize16,
  output logic                         addrsize32,
  output logic [1:0]                   segment,
  output logic [1:0]                   repeat_prefix,
  output logic [3:0]                   reg_field,
  output logic [3:0]                   rm_index,
  output logic                         operand_is_reg,
  output logic                         rip_relative,
  output logic [63:0]                  eff_addr,
  output logic [2:0]                   modrm_len
);

  localparam int RF_AW = $clog2(REG_COUNT);
  localparam int PW    = xmd_pkg::PTR_W;
  localparam int OW    = xmd_pkg::RIP_OFS_W;

  xmd_pkg::state_t state, state_next;

  logic [7:0]       win [xmd_pkg::WIN_MAX];
  logic [119:0]     in_win;
  logic [PW-1:0]    ptr, ptr_next;
  logic [3:0]       off, off_next;
  logic [6:0]       rex, rex_next;
  logic             osz, osz_next, asz, asz_next;
  logic [1:0]       seg, seg_next, rep, rep_next;
  logic [7:0]       modrm, modrm_next;
  logic [RF_AW-1:0] base_num, base_num_next, idx_num, idx_num_next;
  logic             need_idx, need_idx_next;
  logic [1:0]       scale, scale_next;
  logic [2:0]       disp_left, disp_left_next;
  logic [1:0]       disp_idx, disp_idx_next;
  logic             disp8, disp8_next;
  logic [31:0]      disp, disp_next;
  logic [2:0]       len, len_next;
  logic [OW-1:0]    rip_ofs, rip_ofs_next;
  logic [63:0]      iaddr, acc, acc_next;
  logic [1:0]       opc_len;
  logic [3:0]       trail;

  logic [7:0]       cur_byte;
  logic             scan_end, pfx_hit, rex_hit;
  logic [PW-1:0]    ptr_end;
  logic [1:0]       mod_c, reg_mod;
  logic [2:0]       rm_c;
  logic             sib_need_base, sib_need_idx, sib_no_base;
  logic [2:0]       sib_disp;
  logic [63:0]      opnd, rf_data, disp_ext;
  logic [RF_AW-1:0] rf_rd_addr;
  logic             rf_wr_en;

  assign in_win   = {bytes_hi, bytes_lo};
  assign cur_byte = (ptr < PW'(xmd_pkg::WIN_MAX)) ? win[ptr[3:0]] : 8'h00;
  assign scan_end = (ptr == PW'(WINDOW_BYTES));
  assign mod_c    = cur_byte[7:6];
  assign rm_c     = cur_byte[2:0];
  assign reg_mod  = modrm[7:6];

  always_comb begin
    pfx_hit = 1'b1;
    case (cur_byte)
      xmd_pkg::PFX_OPSIZE, xmd_pkg::PFX_ADDRSIZE, xmd_pkg::PFX_FS, xmd_pkg::PFX_GS,
      xmd_pkg::PFX_ES, xmd_pkg::PFX_CS, xmd_pkg::PFX_SS, xmd_pkg::PFX_DS,
      xmd_pkg::PFX_LOCK, xmd_pkg::PFX_REPNE, xmd_pkg::PFX_REP: pfx_hit = 1'b1;
      default: pfx_hit = 1'b0;
    endcase
  end

  assign rex_hit = !pfx_hit && (cur_byte[7:4] == xmd_pkg::REX_HI);
  assign ptr_end = rex_hit ? ptr + PW'(1) : ptr;

  assign sib_no_base   = (cur_byte[2:0] == xmd_pkg::SIB_NOBASE) &&
                         (reg_mod == xmd_pkg::MOD_NODISP);
  assign sib_need_base = !sib_no_base;
  assign sib_need_idx  = !((cur_byte[5:3] == xmd_pkg::SIB_NOIDX) && !rex[1]);
  assign sib_disp      = (reg_mod == xmd_pkg::MOD_DISP8) ? xmd_pkg::DISP_BYTE :
                         ((reg_mod == xmd_pkg::MOD_DISP32) || sib_no_base) ?
                         xmd_pkg::DISP_WORD : xmd_pkg::DISP_NONE;

  assign disp_ext = disp8 ? {{56{disp[7]}}, disp[7:0]} : {{32{disp[31]}}, disp};

  // shared address adder operand
  always_comb begin
    case (state)
      xmd_pkg::ST_RIPA: opnd = iaddr;
      xmd_pkg::ST_RIPB: opnd = 64'(rip_ofs);
      xmd_pkg::ST_ADDB: opnd = rf_data;
      xmd_pkg::ST_ADDI: opnd = rf_data << scale;
      xmd_pkg::ST_ADDD: opnd = disp_ext;
      default:          opnd = '0;
    endcase
  end

  assign rf_wr_en   = (state == xmd_pkg::ST_IDLE) && start && (kind == xmd_pkg::KIND_WRITE);
  assign rf_rd_addr = (state == xmd_pkg::ST_RDI) ? idx_num : base_num;

  xmd_regfile #(
    .WIDTH(64),
    .DEPTH(REG_COUNT)
  ) u_rf (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (rf_wr_en),
    .wr_addr(reg_number),
    .wr_data(reg_value),
    .rd_addr(rf_rd_addr),
    .rd_data(rf_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      xmd_pkg::ST_IDLE: begin
        if (start && (kind == xmd_pkg::KIND_DECODE)) state_next = xmd_pkg::ST_SCAN;
      end
      xmd_pkg::ST_SCAN: begin
        if (scan_end || !pfx_hit) state_next = xmd_pkg::ST_MODRM;
      end
      xmd_pkg::ST_MODRM: begin
        if (mod_c == xmd_pkg::MOD_REG) begin
          state_next = xmd_pkg::ST_DONE;
        end else if ((mod_c == xmd_pkg::MOD_NODISP) && (rm_c == xmd_pkg::RM_RIP)) begin
          state_next = xmd_pkg::ST_RIPA;
        end else if (rm_c == xmd_pkg::RM_SIB) begin
          state_next = xmd_pkg::ST_SIB;
        end else begin
          state_next = xmd_pkg::ST_RDB;
        end
      end
      xmd_pkg::ST_SIB: begin
        if (sib_need_base) state_next = xmd_pkg::ST_RDB;
        else if (sib_need_idx) state_next = xmd_pkg::ST_RDI;
        else state_next = xmd_pkg::ST_DISP;
      end
      xmd_pkg::ST_RIPA: state_next = xmd_pkg::ST_RIPB;
      xmd_pkg::ST_RIPB: state_next = xmd_pkg::ST_DISP;
      xmd_pkg::ST_RDB:  state_next = xmd_pkg::ST_ADDB;
      xmd_pkg::ST_ADDB: begin
        if (need_idx) state_next = xmd_pkg::ST_RDI;
        else if (disp_left != xmd_pkg::DISP_NONE) state_next = xmd_pkg::ST_DISP;
        else state_next = xmd_pkg::ST_DONE;
      end
      xmd_pkg::ST_RDI:  state_next = xmd_pkg::ST_ADDI;
      xmd_pkg::ST_ADDI: begin
        if (disp_left != xmd_pkg::DISP_NONE) state_next = xmd_pkg::ST_DISP;
        else state_next = xmd_pkg::ST_DONE;
      end
      xmd_pkg::ST_DISP: begin
        if (disp_left == 3'd1) state_next = xmd_pkg::ST_ADDD;
      end
      xmd_pkg::ST_ADDD: state_next = xmd_pkg::ST_DONE;
      xmd_pkg::ST_DONE: state_next = xmd_pkg::ST_IDLE;
      default:          state_next = xmd_pkg::ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    ptr_next       = ptr;
    off_next       = off;
    rex_next       = rex;
    osz_next       = osz;
    asz_next       = asz;
    seg_next       = seg;
    rep_next       = rep;
    modrm_next     = modrm;
    base_num_next  = base_num;
    idx_num_next   = idx_num;
    need_idx_next  = need_idx;
    scale_next     = scale;
    disp_left_next = disp_left;
    disp_idx_next  = disp_idx;
    disp8_next     = disp8;
    disp_next      = disp;
    len_next       = len;
    rip_ofs_next   = rip_ofs;
    acc_next       = acc + opnd;
    case (state)
      xmd_pkg::ST_IDLE: begin
        ptr_next = '0;
        rex_next = '0;
        osz_next = 1'b0;
        asz_next = 1'b0;
        seg_next = xmd_pkg::SEG_NONE;
        rep_next = xmd_pkg::REP_NONE;
        acc_next = '0;
      end
      xmd_pkg::ST_SCAN: begin
        if (scan_end || !pfx_hit) begin
          if (!scan_end && rex_hit) rex_next = cur_byte[6:0];
          off_next = ptr_end[3:0];
          ptr_next = ptr_end + PW'(opc_len);
        end else begin
          ptr_next = ptr + PW'(1);
          case (cur_byte)
            xmd_pkg::PFX_OPSIZE:   osz_next = 1'b1;
            xmd_pkg::PFX_ADDRSIZE: asz_next = 1'b1;
            xmd_pkg::PFX_FS:       seg_next = xmd_pkg::SEG_FS;
            xmd_pkg::PFX_GS:       seg_next = xmd_pkg::SEG_GS;
            xmd_pkg::PFX_REPNE:    rep_next = xmd_pkg::REP_F2;
            xmd_pkg::PFX_REP:      rep_next = xmd_pkg::REP_F3;
            default:               ;
          endcase
        end
      end
      xmd_pkg::ST_MODRM: begin
        modrm_next    = cur_byte;
        ptr_next      = ptr + PW'(1);
        len_next      = 3'd1;
        disp_idx_next = '0;
        disp_next     = '0;
        rip_ofs_next  = OW'(ptr) + OW'(5) + OW'(trail);
        base_num_next = RF_AW'({rex[0], rm_c});
        need_idx_next = 1'b0;
        if ((mod_c == xmd_pkg::MOD_NODISP) && (rm_c == xmd_pkg::RM_RIP)) begin
          disp_left_next = xmd_pkg::DISP_WORD;
        end else if (mod_c == xmd_pkg::MOD_DISP8) begin
          disp_left_next = xmd_pkg::DISP_BYTE;
        end else if (mod_c == xmd_pkg::MOD_DISP32) begin
          disp_left_next = xmd_pkg::DISP_WORD;
        end else begin
          disp_left_next = xmd_pkg::DISP_NONE;
        end
        disp8_next = (mod_c == xmd_pkg::MOD_DISP8);
      end
      xmd_pkg::ST_SIB: begin
        ptr_next       = ptr + PW'(1);
        len_next       = 3'd2;
        base_num_next  = RF_AW'({rex[0], cur_byte[2:0]});
        idx_num_next   = RF_AW'({rex[1], cur_byte[5:3]});
        need_idx_next  = sib_need_idx;
        scale_next     = cur_byte[7:6];
        disp_left_next = sib_disp;
        disp8_next     = (sib_disp == xmd_pkg::DISP_BYTE);
      end
      xmd_pkg::ST_DISP: begin
        disp_next[disp_idx*8 +: 8] = cur_byte;
        disp_idx_next  = disp_idx + 2'd1;
        disp_left_next = disp_left - 3'd1;
        ptr_next       = ptr + PW'(1);
        len_next       = len + 3'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xmd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == xmd_pkg::ST_IDLE) && start) begin
      iaddr   <= instr_addr;
      opc_len <= opcode_len;
      trail   <= trailing_imm;
      for (int i = 0; i < xmd_pkg::WIN_MAX; i++) begin
        win[i] <= (i < WINDOW_BYTES) ? in_win[i*8 +: 8] : 8'h00;
      end
    end
    ptr       <= ptr_next;
    off       <= off_next;
    rex       <= rex_next;
    osz       <= osz_next;
    asz       <= asz_next;
    seg       <= seg_next;
    rep       <= rep_next;
    modrm     <= modrm_next;
    base_num  <= base_num_next;
    idx_num   <= idx_num_next;
    need_idx  <= need_idx_next;
    scale     <= scale_next;
    disp_left <= disp_left_next;
    disp_idx  <= disp_idx_next;
    disp8     <= disp8_next;
    disp      <= disp_next;
    len       <= len_next;
    rip_ofs   <= rip_ofs_next;
    acc       <= acc_next;
  end

  // outputs
  always_comb begin
    busy           = (state != xmd_pkg::ST_IDLE);
    done           = (state == xmd_pkg::ST_DONE);
    prefix_len     = off;
    rex_byte       = rex;
    opsize16       = osz;
    addrsize32     = asz;
    segment        = seg;
    repeat_prefix  = rep;
    reg_field      = {rex[2], modrm[5:3]};
    operand_is_reg = (reg_mod == xmd_pkg::MOD_REG);
    rip_relative   = (reg_mod == xmd_pkg::MOD_NODISP) && (modrm[2:0] == xmd_pkg::RM_RIP);
    rm_index       = operand_is_reg ? {rex[0], modrm[2:0]} : 4'd0;
    eff_addr       = (asz && !rip_relative) ? (acc & xmd_pkg::ADDR32_MASK) : acc;
    modrm_len      = len;
  end

endmodule

/* hdl/xmd_checker.sv */
// xmd_checker: port-level assertions for the decoder, bound to the top level.
// Depends on xmd_pkg and x86_64_prefix_modrm_decoder.
module xmd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        kind,
  input logic        done,
  input logic        operand_is_reg,
  input logic        rip_relative,
  input logic [63:0] eff_addr,
  input logic [2:0]  modrm_len
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result beat outside a decode");

  a_decode_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == xmd_pkg::KIND_DECODE)) |=> busy)
    else $error("decode beat did not start the sequencer");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == xmd_pkg::KIND_WRITE)) |=> !busy && !done)
    else $error("register write left the block busy");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done) else $error("strobe not followed by idle");

  a_reg_operand: assert property (@(posedge clk) disable iff (rst)
    (done && operand_is_reg) |-> (eff_addr == 64'd0) && (modrm_len == 3'd1) && !rip_relative)
    else $error("register operand with memory fields");

endmodule

bind x86_64_prefix_modrm_decoder xmd_checker u_xmd_checker (.*);
